// File: rtl/core/wcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_pkg
// Shared constants and codes for the weighted channel picker.
// ----------------------------------------------------------------------------
package wcp_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int CHAN_W   = 16;
   localparam int WEIGHT_W = 17;
   localparam int RAND_W   = 16;
   localparam int QIDX_W   = 8;
   localparam int PROB_W   = 17;
   localparam int STATUS_W = 3;
   localparam int KIND_W   = 2;

   // running total of up to TABLE_DEPTH weights of WEIGHT_W bits
   localparam int TOTAL_W  = WEIGHT_W + ADDR_W;
   localparam int PROD_W   = RAND_W + TOTAL_W;
   localparam int ENTRY_W  = CHAN_W + WEIGHT_W + TOTAL_W;

   localparam int ONE_Q16       = 65536;
   localparam int TOLERANCE_Q16 = 65;
   localparam int NORM_HIGH     = ONE_Q16 + TOLERANCE_Q16;
   localparam int NORM_LOW      = ONE_Q16 - TOLERANCE_Q16;

   // quotient bits of weight * 65536 / total, which never exceeds 65536
   localparam int DIV_STEPS = PROB_W;
   localparam int STEP_W    = $clog2(DIV_STEPS + 1);

   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ADD_NORM  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd4;

endpackage

// File: rtl/core/wcp_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_req_if
// Request channel: add, draw or query transactions with valid/ready.
// ----------------------------------------------------------------------------
interface wcp_req_if;
   logic                         valid;
   logic                         ready;
   logic [wcp_pkg::KIND_W-1:0]   kind;
   logic [wcp_pkg::CHAN_W-1:0]   channel_id;
   logic [wcp_pkg::WEIGHT_W-1:0] weight;
   logic [wcp_pkg::RAND_W-1:0]   random_value;
   logic [wcp_pkg::QIDX_W-1:0]   query_index;

   modport source (output valid, kind, channel_id, weight, random_value, query_index,
                   input ready);
   modport sink (input valid, kind, channel_id, weight, random_value, query_index,
                 output ready);
endinterface

// File: rtl/core/wcp_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_rsp_if
// Response channel: picked channel, probability and status with valid/ready.
// ----------------------------------------------------------------------------
interface wcp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wcp_pkg::CHAN_W-1:0]   picked_channel;
   logic [wcp_pkg::PROB_W-1:0]   probability;
   logic [wcp_pkg::STATUS_W-1:0] status;

   modport source (output valid, picked_channel, probability, status, input ready);
   modport sink (input valid, picked_channel, probability, status, output ready);
endinterface

// File: rtl/core/wcp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wcp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/weighted_channel_picker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_channel_picker
// Channel table with Q1.16 weights and inverse-CDF draw on a supplied random.
// ----------------------------------------------------------------------------
//  channel   direction  handshake     contents
//  req_port  in         valid/ready   kind, channel_id, weight, random_value,
//                                     query_index
//  rsp_port  out        valid/ready   picked_channel, probability, status
//
//  One transaction at a time; req_port.ready is high only while idle.
//  Add, error cases and unused kinds go straight to S_DONE. Draw: a multiply up front,
//  then the entries are scanned in order through the single table read port.
//  Query: a table read, then when normalised the restoring divider, one quotient bit a cycle.
//  A new request is taken while the previous response waits on rsp_port.ready; a finished
//  result stalls only if that register is full. Reset empties table, total and flag.
// ----------------------------------------------------------------------------
module weighted_channel_picker (
   input  logic      clock,
   input  logic      reset,
   wcp_req_if.sink   req_port,
   wcp_rsp_if.source rsp_port
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   localparam int CHAN_LO   = wcp_pkg::WEIGHT_W + wcp_pkg::TOTAL_W;
   localparam int WEIGHT_LO = wcp_pkg::TOTAL_W;
   localparam int QCMP_W    = wcp_pkg::CNT_W + wcp_pkg::QIDX_W;

   logic [2:0]                     state_ff, state_in;
   logic [wcp_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [wcp_pkg::TOTAL_W-1:0]    total_ff, total_in;
   logic                           norm_ff, norm_in;
   logic [wcp_pkg::KIND_W-1:0]     kind_ff, kind_in;
   logic [wcp_pkg::RAND_W-1:0]     rnd_ff, rnd_in;
   logic [wcp_pkg::ADDR_W-1:0]     qaddr_ff, qaddr_in;
   logic [wcp_pkg::ADDR_W-1:0]     idx_ff, idx_in;
   logic [wcp_pkg::PROD_W-1:0]     prod_ff, prod_in;
   logic [wcp_pkg::TOTAL_W-1:0]    rem_ff, rem_in;
   logic [wcp_pkg::WEIGHT_W-1:0]   dsh_ff, dsh_in;
   logic [wcp_pkg::STEP_W-1:0]     step_ff, step_in;
   logic [wcp_pkg::CHAN_W-1:0]     pick_ff, pick_in;
   logic [wcp_pkg::PROB_W-1:0]     prob_ff, prob_in;
   logic [wcp_pkg::STATUS_W-1:0]   status_ff, status_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [wcp_pkg::CHAN_W-1:0]     rsp_pick_ff, rsp_pick_in;
   logic [wcp_pkg::PROB_W-1:0]     rsp_prob_ff, rsp_prob_in;
   logic [wcp_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                           accept;
   logic                           off_norm;
   logic                           wr_en;
   logic [wcp_pkg::TOTAL_W-1:0]    sum;
   logic [wcp_pkg::ADDR_W-1:0]     rd_addr;
   logic [wcp_pkg::ENTRY_W-1:0]    rd_data;
   logic [wcp_pkg::CHAN_W-1:0]     rd_chan;
   logic [wcp_pkg::WEIGHT_W-1:0]   rd_weight;
   logic [wcp_pkg::TOTAL_W-1:0]    rd_bound;
   logic                           hit;
   logic                           last;
   logic [wcp_pkg::TOTAL_W:0]      trial;
   logic                           qbit;

   assign accept = req_port.valid && req_port.ready;
   assign req_port.ready = (state_ff == S_IDLE);

   assign sum = total_ff + wcp_pkg::TOTAL_W'(req_port.weight);
   assign off_norm = (total_ff > wcp_pkg::TOTAL_W'(wcp_pkg::NORM_HIGH))
                  || (total_ff < wcp_pkg::TOTAL_W'(wcp_pkg::NORM_LOW));

   assign wr_en = accept && (req_port.kind == wcp_pkg::KIND_ADD) && !norm_ff
               && (count_ff < wcp_pkg::CNT_W'(wcp_pkg::TABLE_DEPTH));

   assign rd_addr = (kind_ff == wcp_pkg::KIND_DRAW) ? idx_ff : qaddr_ff;

   wcp_ram #(
      .WIDTH(wcp_pkg::ENTRY_W),
      .DEPTH(wcp_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[wcp_pkg::ADDR_W-1:0]),
      .wr_data ({req_port.channel_id, req_port.weight, sum}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_chan   = rd_data[CHAN_LO +: wcp_pkg::CHAN_W];
   assign rd_weight = rd_data[WEIGHT_LO +: wcp_pkg::WEIGHT_W];
   assign rd_bound  = rd_data[wcp_pkg::TOTAL_W-1:0];

   // normalised: random * total < bound * 65536
   assign hit = norm_ff ? (prod_ff < {rd_bound, 16'd0})
                        : (wcp_pkg::TOTAL_W'(rnd_ff) < rd_bound);
   assign last = (wcp_pkg::CNT_W'(idx_ff) + wcp_pkg::CNT_W'(1)) == count_ff;

   // restoring divider step
   assign trial = {rem_ff, dsh_ff[wcp_pkg::WEIGHT_W-1]};
   assign qbit  = trial >= {1'b0, total_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      norm_in       = norm_ff;
      kind_in       = kind_ff;
      rnd_in        = rnd_ff;
      qaddr_in      = qaddr_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      dsh_in        = dsh_ff;
      step_in       = step_ff;
      pick_in       = pick_ff;
      prob_in       = prob_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_pick_in   = rsp_pick_ff;
      rsp_prob_in   = rsp_prob_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in   = req_port.kind;
               rnd_in    = req_port.random_value;
               qaddr_in  = req_port.query_index[wcp_pkg::ADDR_W-1:0];
               idx_in    = '0;
               pick_in   = '0;
               prob_in   = '0;
               status_in = wcp_pkg::ST_OK;
               state_in  = S_DONE;
               unique case (req_port.kind)
                  wcp_pkg::KIND_ADD: begin
                     if (norm_ff) begin
                        status_in = wcp_pkg::ST_ADD_NORM;
                     end else if (!wr_en) begin
                        status_in = wcp_pkg::ST_FULL;
                     end else begin
                        total_in = sum;
                        count_in = count_ff + wcp_pkg::CNT_W'(1);
                     end
                  end
                  wcp_pkg::KIND_DRAW: begin
                     if (count_ff == '0) begin
                        status_in = wcp_pkg::ST_EMPTY;
                     end else begin
                        norm_in  = norm_ff || off_norm;
                        state_in = S_MUL;
                     end
                  end
                  wcp_pkg::KIND_QUERY: begin
                     if (QCMP_W'(req_port.query_index) >= QCMP_W'(count_ff)) begin
                        status_in = wcp_pkg::ST_BAD_INDEX;
                     end else begin
                        norm_in  = norm_ff || off_norm;
                        state_in = S_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MUL: begin
            prod_in  = wcp_pkg::PROD_W'(rnd_ff) * wcp_pkg::PROD_W'(total_ff);
            state_in = S_RD;
         end
         S_RD: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (kind_ff == wcp_pkg::KIND_DRAW) begin
               // last entry read is the fallback when no bound is hit
               pick_in = rd_chan;
               if (hit || last) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + wcp_pkg::ADDR_W'(1);
                  state_in = S_RD;
               end
            end else if (!norm_ff) begin
               prob_in  = rd_weight;
               state_in = S_DONE;
            end else if (total_ff == '0) begin
               prob_in  = '0;
               state_in = S_DONE;
            end else begin
               // weight <= total, so the upper dividend bits sit below the divisor
               rem_in   = wcp_pkg::TOTAL_W'(rd_weight[wcp_pkg::WEIGHT_W-1:1]);
               dsh_in   = {rd_weight[0], (wcp_pkg::WEIGHT_W-1)'(0)};
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = qbit ? wcp_pkg::TOTAL_W'(trial - {1'b0, total_ff})
                           : wcp_pkg::TOTAL_W'(trial);
            dsh_in  = {dsh_ff[wcp_pkg::WEIGHT_W-2:0], 1'b0};
            prob_in = {prob_ff[wcp_pkg::PROB_W-2:0], qbit};
            step_in = step_ff + wcp_pkg::STEP_W'(1);
            if (step_ff == wcp_pkg::STEP_W'(wcp_pkg::DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_pick_in   = pick_ff;
               rsp_prob_in   = prob_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         norm_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         norm_ff      <= norm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      rnd_ff        <= rnd_in;
      qaddr_ff      <= qaddr_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      rem_ff        <= rem_in;
      dsh_ff        <= dsh_in;
      step_ff       <= step_in;
      pick_ff       <= pick_in;
      prob_ff       <= prob_in;
      status_ff     <= status_in;
      rsp_pick_ff   <= rsp_pick_in;
      rsp_prob_ff   <= rsp_prob_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.picked_channel = rsp_pick_ff;
   assign rsp_port.probability    = rsp_prob_ff;
   assign rsp_port.status         = rsp_status_ff;

endmodule

// File: rtl/core/wcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcp_checker
// Port-level checks on the weighted channel picker, bound to the top level.
// ----------------------------------------------------------------------------
module wcp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [wcp_pkg::CHAN_W-1:0]   picked_channel,
   input logic [wcp_pkg::PROB_W-1:0]   probability,
   input logic [wcp_pkg::STATUS_W-1:0] status
);

   // one transaction in flight: busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous transaction still in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(picked_channel)
         && $stable(probability) && $stable(status))
      else $error("stalled response changed or dropped");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status == wcp_pkg::ST_OK || status == wcp_pkg::ST_FULL
         || status == wcp_pkg::ST_ADD_NORM || status == wcp_pkg::ST_EMPTY
         || status == wcp_pkg::ST_BAD_INDEX)
      else $error("unknown status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status != wcp_pkg::ST_OK |-> picked_channel == '0
         && probability == '0)
      else $error("error response carries nonzero data");

   // a response can only rise out of a busy state, never straight out of idle
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised without a transaction in progress");

endmodule

bind weighted_channel_picker wcp_checker u_wcp_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .picked_channel (rsp_port.picked_channel),
   .probability    (rsp_port.probability),
   .status         (rsp_port.status)
);

// File: tb/sv/tb_weighted_channel_picker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_channel_picker
// Self-checking bench for the weighted channel picker. A directed table covers
// empty-table errors, table building, edge draws and queries; random traffic
// then runs adds, draws and queries on the table as built, fills it, and runs on the
// normalised table. Each response is checked against its row or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_weighted_channel_picker;

   localparam logic [wcp_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 40;

   typedef struct packed {
      logic [wcp_pkg::KIND_W-1:0]   kind;
      logic [wcp_pkg::CHAN_W-1:0]   channel_id;
      logic [wcp_pkg::WEIGHT_W-1:0] weight;
      logic [wcp_pkg::RAND_W-1:0]   random_value;
      logic [wcp_pkg::QIDX_W-1:0]   query_index;
   } pick_req_type;

   typedef struct packed {
      logic [wcp_pkg::CHAN_W-1:0]   picked_channel;
      logic [wcp_pkg::PROB_W-1:0]   probability;
      logic [wcp_pkg::STATUS_W-1:0] status;
   } pick_rsp_type;

   typedef struct packed {
      pick_req_type req;
      logic         typed;
      pick_rsp_type rsp;
   } stim_row_type;

   logic clock;
   logic reset;

   wcp_req_if req_bus ();
   wcp_rsp_if rsp_bus ();

   weighted_channel_picker u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // predictor state
   logic [wcp_pkg::CHAN_W-1:0]   tab_channel [wcp_pkg::TABLE_DEPTH];
   logic [wcp_pkg::WEIGHT_W-1:0] tab_weight  [wcp_pkg::TABLE_DEPTH];
   logic [wcp_pkg::TOTAL_W-1:0]  tab_bound   [wcp_pkg::TABLE_DEPTH];
   int                           entries;
   logic [wcp_pkg::TOTAL_W-1:0]  total_weight;
   bit                           normalised;

   pick_rsp_type pending_outcomes [$];
   stim_row_type stim_table [$];

   int mismatch_count;
   int result_count;
   int quiet_cycles;
   bit calm;
   bit hold_req;
   bit zero_total_run;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s at result %0d: got %0h, want %0h",
               what, result_count, got, want);
      mismatch_count++;
   endtask

   function automatic void update_normalised();
      logic [wcp_pkg::TOTAL_W-1:0] diff;
      if (!normalised) begin
         diff = (total_weight > wcp_pkg::TOTAL_W'(wcp_pkg::ONE_Q16))
              ? total_weight - wcp_pkg::TOTAL_W'(wcp_pkg::ONE_Q16)
              : wcp_pkg::TOTAL_W'(wcp_pkg::ONE_Q16) - total_weight;
         if (diff > wcp_pkg::TOTAL_W'(wcp_pkg::TOLERANCE_Q16))
            normalised = 1'b1;
      end
   endfunction

   function automatic pick_rsp_type pick_outcome(input pick_req_type r);
      pick_rsp_type o;
      logic [63:0]  scaled_rnd;
      logic [63:0]  scaled_bound;
      bit           hit;
      o = '0;
      unique case (r.kind)
         wcp_pkg::KIND_ADD: begin
            if (normalised) begin
               o.status = wcp_pkg::ST_ADD_NORM;
            end else if (entries >= wcp_pkg::TABLE_DEPTH) begin
               o.status = wcp_pkg::ST_FULL;
            end else begin
               total_weight = total_weight + wcp_pkg::TOTAL_W'(r.weight);
               tab_channel[wcp_pkg::ADDR_W'(entries)] = r.channel_id;
               tab_weight[wcp_pkg::ADDR_W'(entries)]  = r.weight;
               tab_bound[wcp_pkg::ADDR_W'(entries)]   = total_weight;
               entries++;
            end
         end
         wcp_pkg::KIND_DRAW: begin
            if (entries == 0) begin
               o.status = wcp_pkg::ST_EMPTY;
            end else begin
               update_normalised();
               // no bound above the random falls back to the last channel
               o.picked_channel = tab_channel[wcp_pkg::ADDR_W'(entries - 1)];
               hit = 1'b0;
               for (int i = 0; i < entries; i++) begin
                  scaled_rnd   = 64'(r.random_value) * 64'(total_weight);
                  scaled_bound = 64'(tab_bound[wcp_pkg::ADDR_W'(i)]) << 16;
                  if (!hit && (normalised ? (scaled_rnd < scaled_bound)
                                          : (wcp_pkg::TOTAL_W'(r.random_value)
                                             < tab_bound[wcp_pkg::ADDR_W'(i)]))) begin
                     hit = 1'b1;
                     o.picked_channel = tab_channel[wcp_pkg::ADDR_W'(i)];
                  end
               end
            end
         end
         wcp_pkg::KIND_QUERY: begin
            if (int'(r.query_index) >= entries) begin
               o.status = wcp_pkg::ST_BAD_INDEX;
            end else begin
               update_normalised();
               if (!normalised)
                  o.probability = tab_weight[r.query_index[wcp_pkg::ADDR_W-1:0]];
               else if (total_weight != '0)
                  o.probability = wcp_pkg::PROB_W'(
                     (64'(tab_weight[r.query_index[wcp_pkg::ADDR_W-1:0]]) << 16)
                     / 64'(total_weight));
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   // random value near one of the stored bounds, or anywhere
   function automatic logic [wcp_pkg::RAND_W-1:0] pick_random_value();
      logic [63:0] cut;
      int          k;
      if (entries == 0 || $urandom_range(0, 2) != 0)
         return wcp_pkg::RAND_W'($urandom);
      k = $urandom_range(0, entries - 1);
      if (normalised && total_weight != '0)
         cut = (64'(tab_bound[wcp_pkg::ADDR_W'(k)]) << 16) / 64'(total_weight);
      else
         cut = 64'(tab_bound[wcp_pkg::ADDR_W'(k)]);
      cut = cut + $urandom_range(0, 2) - 1;
      return (cut > 64'hFFFF) ? '1 : wcp_pkg::RAND_W'(cut);
   endfunction

   function automatic pick_req_type random_add(input logic [wcp_pkg::WEIGHT_W-1:0] w);
      pick_req_type it;
      it.kind         = wcp_pkg::KIND_ADD;
      it.channel_id   = wcp_pkg::CHAN_W'($urandom);
      it.weight       = w;
      it.random_value = wcp_pkg::RAND_W'($urandom);
      it.query_index  = wcp_pkg::QIDX_W'($urandom);
      return it;
   endfunction

   function automatic pick_req_type make_item();
      pick_req_type it;
      int           pick;
      it.kind         = KIND_SPARE;
      it.channel_id   = wcp_pkg::CHAN_W'($urandom);
      it.weight       = wcp_pkg::WEIGHT_W'($urandom);
      it.random_value = wcp_pkg::RAND_W'($urandom);
      it.query_index  = wcp_pkg::QIDX_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10 && (normalised || entries < 12)) begin
         it.kind = wcp_pkg::KIND_ADD;
         // before normalisation keep the total inside the tolerance band
         if (zero_total_run)
            it.weight = '0;
         else if (!normalised)
            it.weight = (total_weight < wcp_pkg::TOTAL_W'(wcp_pkg::NORM_HIGH))
                      ? wcp_pkg::WEIGHT_W'($urandom_range(0,
                           wcp_pkg::NORM_HIGH - int'(total_weight)))
                      : '0;
      end else if (pick < 55) begin
         it.kind         = wcp_pkg::KIND_DRAW;
         it.random_value = pick_random_value();
      end else if (pick < 94) begin
         it.kind = wcp_pkg::KIND_QUERY;
         if ($urandom_range(0, 4) != 0)
            it.query_index = wcp_pkg::QIDX_W'($urandom_range(0, entries + 1));
      end
      return it;
   endfunction

   function automatic void append_row(input logic [wcp_pkg::KIND_W-1:0] kind,
                                      input logic [wcp_pkg::CHAN_W-1:0] chan,
                                      input logic [wcp_pkg::WEIGHT_W-1:0] w,
                                      input logic [wcp_pkg::RAND_W-1:0] rnd,
                                      input logic [wcp_pkg::QIDX_W-1:0] qidx,
                                      input logic typed,
                                      input logic [wcp_pkg::CHAN_W-1:0] picked,
                                      input logic [wcp_pkg::PROB_W-1:0] prob,
                                      input logic [wcp_pkg::STATUS_W-1:0] status);
      stim_row_type row;
      row.req = '{kind, chan, w, rnd, qidx};
      row.typed = typed;
      row.rsp = '{picked, prob, status};
      stim_table.insert(stim_table.size(), row);
   endfunction

   // entered and left on a falling edge
   task automatic send_req(input pick_req_type it, input bit typed,
                           input pick_rsp_type typed_rsp);
      pick_rsp_type predicted;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.kind         <= it.kind;
      req_bus.channel_id   <= it.channel_id;
      req_bus.weight       <= it.weight;
      req_bus.random_value <= it.random_value;
      req_bus.query_index  <= it.query_index;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = pick_outcome(it);
      pending_outcomes.insert(pending_outcomes.size(), typed ? typed_rsp : predicted);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_outcomes.size() != 0) @(negedge clock);
   endtask

   // response side: random stalls plus one long hold-off on request
   initial begin : rsp_drain
      int stall;
      rsp_bus.ready = 1'b0;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall = $urandom_range(1, 12) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      pick_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected transaction", 32'(rsp_bus.status), '0);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_bus.picked_channel !== want.picked_channel)
               report_mismatch("picked_channel", 32'(rsp_bus.picked_channel),
                               32'(want.picked_channel));
            if (rsp_bus.probability !== want.probability)
               report_mismatch("probability", 32'(rsp_bus.probability),
                               32'(want.probability));
            if (rsp_bus.status !== want.status)
               report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
         end
         result_count++;
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type row;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.kind         = '0;
      req_bus.channel_id   = '0;
      req_bus.weight       = '0;
      req_bus.random_value = '0;
      req_bus.query_index  = '0;
      hold_req             = 1'b0;
      calm                 = 1'b0;
      mismatch_count       = 0;
      result_count         = 0;
      quiet_cycles         = 0;
      entries              = 0;
      total_weight         = '0;
      normalised           = 1'b0;
      // now and then build an all-zero table, which normalises to a zero total
      zero_total_run       = ($urandom_range(0, 3) == 0);

      // empty table, unused kind
      append_row(wcp_pkg::KIND_DRAW, 16'h0, 17'h0, 16'h0, 8'h0,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_EMPTY);
      append_row(wcp_pkg::KIND_QUERY, 16'h0, 17'h0, 16'h0, 8'h0,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_BAD_INDEX);
      append_row(wcp_pkg::KIND_QUERY, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 8'hFF,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_BAD_INDEX);
      append_row(KIND_SPARE, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 8'hFF,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_OK);
      // table summing to exactly one, with a zero-weight entry
      append_row(wcp_pkg::KIND_ADD, 16'h0000, 17'h04000, 16'h0, 8'h0,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_ADD, 16'hFFFF, 17'h04000, 16'hFFFF, 8'hFF,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_ADD, 16'h1234, 17'h00000, 16'h0, 8'h0,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_ADD, 16'hABCD, 17'h08000, 16'h0, 8'h0,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_OK);
      // draws either side of the bounds
      append_row(wcp_pkg::KIND_DRAW, 16'h0, 17'h0, 16'h0000, 8'h0,
                 1'b1, 16'h0000, 17'h0, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_DRAW, 16'h0, 17'h0, 16'h3FFF, 8'h0,
                 1'b1, 16'h0000, 17'h0, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_DRAW, 16'h0, 17'h0, 16'h4000, 8'h0,
                 1'b1, 16'hFFFF, 17'h0, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_DRAW, 16'h0, 17'h0, 16'hFFFF, 8'h0,
                 1'b1, 16'hABCD, 17'h0, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_QUERY, 16'h0, 17'h0, 16'h0, 8'h1,
                 1'b1, 16'h0, 17'h04000, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_QUERY, 16'h0, 17'h0, 16'h0, 8'h2,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_QUERY, 16'h0, 17'h0, 16'h0, 8'h4,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_BAD_INDEX);
      // total lands right on the edge of the tolerance, still not normalised
      append_row(wcp_pkg::KIND_ADD, 16'h5555, 17'd65, 16'h0, 8'h0,
                 1'b1, 16'h0, 17'h0, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_DRAW, 16'h0, 17'h0, 16'h8000, 8'h0,
                 1'b1, 16'hABCD, 17'h0, wcp_pkg::ST_OK);
      append_row(wcp_pkg::KIND_QUERY, 16'h0, 17'h0, 16'h0, 8'h4,
                 1'b1, 16'h0, 17'd65, wcp_pkg::ST_OK);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (zero_total_run && row.req.kind == wcp_pkg::KIND_ADD)
            row.req.weight = '0;
         send_req(row.req, row.typed && !zero_total_run, row.rsp);
      end

      // traffic on the table as built, normally still unnormalised
      for (int n = 0; n < 500; n++) begin
         if (n == 150)
            hold_req = 1'b1;
         if (n == 300)
            wait_for_results();
         calm = (n >= 350 && n < 420);
         send_req(make_item(), 1'b0, '0);
      end
      calm = 1'b0;

      // fill the table with weights that push the total out of tolerance
      while (!normalised && entries < wcp_pkg::TABLE_DEPTH)
         send_req(random_add(zero_total_run ? '0
                             : wcp_pkg::WEIGHT_W'($urandom_range(1024, 131071))),
                  1'b0, '0);
      repeat (3)
         send_req(random_add(wcp_pkg::WEIGHT_W'($urandom)), 1'b0, '0);

      // normalised table from the first draw or query on
      for (int n = 0; n < 1020; n++) begin
         if (n == 500)
            hold_req = 1'b1;
         calm = (n >= 870);
         send_req(make_item(), 1'b0, '0);
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
